// ===== design/lmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver package
// Shared widths, reset values, codes and the item record passed from the
// front end through the request queue to the scan engine.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  localparam int NUM_ROWS_DEF = 4;
  localparam int ROW_BITS_DEF = 256;

  localparam int TICK_W    = 20;
  localparam int PANEL_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;
  localparam int ROW_W     = 2;
  localparam int COL_W     = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0]  LATCH_TICKS_RST  = TICK_W'(500);
  localparam logic [TICK_W-1:0]  SETTLE_TICKS_RST = TICK_W'(500);
  localparam logic [TICK_W-1:0]  HOLD_TICKS_RST   = TICK_W'(49000);
  localparam logic [PANEL_W-1:0] PANEL_COUNT_RST  = PANEL_W'(1);

  // Pixels per chained panel
  localparam int PANEL_BITS = 32;

  // Request command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATCH_TICKS  = 2'd0,
    CFG_SETTLE_TICKS = 2'd1,
    CFG_HOLD_TICKS   = 2'd2,
    CFG_PANEL_COUNT  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ITEM_TICK  = 2'd0,
    ITEM_WRITE = 2'd1,
    ITEM_DROP  = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
  } lmsd_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  latch_ticks;
    logic [TICK_W-1:0]  settle_ticks;
    logic [TICK_W-1:0]  hold_ticks;
    logic [PANEL_W-1:0] panel_count;
  } lmsd_cfg_t;

endpackage

// ===== design/lmsd_front.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver front end
// Accepts requests, sorts them into ticks, pixel writes and dropped writes,
// and holds them in a short queue for the scan engine.
// ----------------------------------------------------------------------------
module lmsd_front
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  logic [ROW_W-1:0] pixel_row,
  input  logic [COL_W-1:0] pixel_col,
  input  logic             pixel_value,
  input  logic             clearing,
  output logic             q_valid,
  output lmsd_item_t       q_item,
  input  logic             q_pop
);

  lmsd_item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    push;
  logic                    in_range;
  lmsd_item_t              item_in;

  // Classify the incoming request
  always_comb begin
    in_range = (32'(pixel_row) < NUM_ROWS) && (32'(pixel_col) < ROW_BITS);
    item_in.row   = pixel_row;
    item_in.col   = pixel_col;
    item_in.value = pixel_value;
    if (cmd == CMD_WRITE) begin
      item_in.kind = in_range ? ITEM_WRITE : ITEM_DROP;
    end else begin
      item_in.kind = ITEM_TICK;
    end
  end

  // Hold off requests while the queue is full or the frame store is clearing
  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH)) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (q_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/lmsd_back.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver scan engine
// Owns the frame store and the pin sequencer. Takes one queued request per
// cycle unless stalled or clearing; applies it; presents the pin levels.
// ----------------------------------------------------------------------------
module lmsd_back
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  lmsd_cfg_t  cfg,
  input  logic       q_valid,
  input  lmsd_item_t q_item,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       addr_a,
  output logic       addr_b,
  output logic       latch,
  output logic       shift_clock,
  output logic       serial_data,
  output logic       output_enable
);

  localparam int MEM_DEPTH  = NUM_ROWS * ROW_BITS;
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int RW         = $clog2(NUM_ROWS);
  localparam int CW         = $clog2(ROW_BITS);
  localparam int MAX_PANELS = ROW_BITS / PANEL_BITS;
  localparam int PW         = $clog2(MAX_PANELS + 1);

  typedef enum logic [2:0] {
    PH_ROW_START,
    PH_LATCH,
    PH_SETTLE,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_HOLD_START,
    PH_HOLD
  } phase_t;

  typedef enum logic [1:0] {
    DATA_KEEP,
    DATA_ONE,
    DATA_MEM
  } data_op_t;

  logic          frame_mem [MEM_DEPTH];
  logic [AW-1:0] clr_addr;
  logic          rdata;

  phase_t            phase, phase_next;
  logic [RW-1:0]     scan_row, scan_row_next;
  logic [CW-1:0]     bit_index, bit_index_next;
  logic [TICK_W-1:0] wait_count, wait_count_next;
  logic              a_level, a_level_next;
  logic              b_level, b_level_next;
  logic              pin_a, pin_a_next;
  logic              pin_b, pin_b_next;
  logic              pin_lat, pin_lat_next;
  logic              pin_clk, pin_clk_next;
  logic              data_level;
  logic              data_sel;
  data_op_t          data_op;
  logic              do_begin;
  logic              rd_en;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [PW-1:0]     panels;
  logic [CW:0]       row_len;
  logic [CW-1:0]     last_idx;
  logic [TICK_W-1:0] latch_wait;
  logic [TICK_W-1:0] settle_wait;
  logic [TICK_W-1:0] hold_wait;

  // Take a request when the result slot is free or being taken
  assign q_pop = q_valid && !clearing && (!out_valid || !out_stall);

  // Effective configuration: zero counts act as one, panel count clamped
  always_comb begin
    latch_wait  = (cfg.latch_ticks  == '0) ? '0 : cfg.latch_ticks  - TICK_W'(1);
    settle_wait = (cfg.settle_ticks == '0) ? '0 : cfg.settle_ticks - TICK_W'(1);
    hold_wait   = (cfg.hold_ticks   == '0) ? '0 : cfg.hold_ticks   - TICK_W'(1);
    if (cfg.panel_count == '0) begin
      panels = PW'(1);
    end else if (32'(cfg.panel_count) > MAX_PANELS) begin
      panels = PW'(MAX_PANELS);
    end else begin
      panels = PW'(cfg.panel_count);
    end
    row_len  = (CW + 1)'(panels) * (CW + 1)'(PANEL_BITS);
    last_idx = CW'(row_len - (CW + 1)'(1));
  end

  // Frame store addresses
  assign raddr = AW'(scan_row) * AW'(ROW_BITS) + AW'(bit_index);
  assign waddr = AW'(q_item.row) * AW'(ROW_BITS) + AW'(q_item.col);

  // Pin sequencer: next state for one tick
  always_comb begin
    phase_next      = phase;
    scan_row_next   = scan_row;
    bit_index_next  = bit_index;
    wait_count_next = wait_count;
    a_level_next    = a_level;
    b_level_next    = b_level;
    pin_a_next      = pin_a;
    pin_b_next      = pin_b;
    pin_lat_next    = pin_lat;
    pin_clk_next    = pin_clk;
    data_op         = DATA_KEEP;
    rd_en           = 1'b0;
    do_begin        = 1'b0;
    case (phase)
      PH_ROW_START: begin
        do_begin = 1'b1;
      end
      PH_LATCH: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - TICK_W'(1);
        end else begin
          pin_lat_next    = 1'b0;
          wait_count_next = settle_wait;
          phase_next      = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - TICK_W'(1);
        end else begin
          pin_clk_next = 1'b1;
          data_op      = DATA_MEM;
          rd_en        = 1'b1;
          phase_next   = PH_BIT_LOW;
        end
      end
      PH_BIT_HIGH: begin
        pin_clk_next = 1'b1;
        data_op      = DATA_MEM;
        rd_en        = 1'b1;
        phase_next   = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        pin_clk_next = 1'b0;
        if (bit_index >= last_idx) begin
          bit_index_next = '0;
          phase_next     = PH_HOLD_START;
        end else begin
          bit_index_next = bit_index + CW'(1);
          phase_next     = PH_BIT_HIGH;
        end
      end
      PH_HOLD_START: begin
        pin_clk_next    = 1'b1;
        data_op         = DATA_ONE;
        wait_count_next = hold_wait;
        phase_next      = PH_HOLD;
      end
      PH_HOLD: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - TICK_W'(1);
        end else begin
          scan_row_next = (scan_row == RW'(NUM_ROWS - 1)) ? '0 : scan_row + RW'(1);
          do_begin      = 1'b1;
        end
      end
      default: begin
        phase_next = PH_ROW_START;
      end
    endcase

    // Start of a row: step the address lines and raise latch
    if (do_begin) begin
      a_level_next = !a_level;
      pin_a_next   = !a_level;
      pin_lat_next = 1'b1;
      if (!a_level) begin
        b_level_next = !b_level;
        pin_b_next   = !b_level;
      end
      bit_index_next  = '0;
      wait_count_next = latch_wait;
      phase_next      = PH_LATCH;
    end
  end

  // Frame store: clearing pass, pixel writes and bit reads
  always_ff @(posedge clk) begin
    if (clearing) begin
      frame_mem[clr_addr] <= 1'b0;
    end else if (q_pop && q_item.kind == ITEM_WRITE) begin
      frame_mem[waddr] <= q_item.value;
    end
    if (q_pop && q_item.kind == ITEM_TICK && rd_en) begin
      rdata <= frame_mem[raddr];
    end
  end

  // Sequencer state, result slot and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ROW_START;
      scan_row   <= '0;
      bit_index  <= '0;
      wait_count <= '0;
      a_level    <= 1'b1;
      b_level    <= 1'b1;
      pin_a      <= 1'b0;
      pin_b      <= 1'b0;
      pin_lat    <= 1'b0;
      pin_clk    <= 1'b0;
      data_level <= 1'b1;
      data_sel   <= 1'b0;
      out_valid  <= 1'b0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.kind == ITEM_TICK) begin
          phase      <= phase_next;
          scan_row   <= scan_row_next;
          bit_index  <= bit_index_next;
          wait_count <= wait_count_next;
          a_level    <= a_level_next;
          b_level    <= b_level_next;
          pin_a      <= pin_a_next;
          pin_b      <= pin_b_next;
          pin_lat    <= pin_lat_next;
          pin_clk    <= pin_clk_next;
          // fold the previous data level unless this tick sets it
          data_level <= (data_op == DATA_ONE) ? 1'b1 : serial_data;
          data_sel   <= (data_op == DATA_MEM);
        end else begin
          // fold the previous data level before applying this request
          data_level <= serial_data;
          data_sel   <= 1'b0;
        end
      end
    end
  end

  // Result pin levels
  assign addr_a        = pin_a;
  assign addr_b        = pin_b;
  assign latch         = pin_lat;
  assign shift_clock   = pin_clk;
  assign serial_data   = data_sel ? !rdata : data_level;
  assign output_enable = 1'b1;

  // Latch is high exactly during the latch wait
  assert property (@(posedge clk) disable iff (rst) pin_lat == (phase == PH_LATCH))
    else $error("latch level out of step with sequencer phase");

  // Clock is high while a bit is on the line and while the row is held
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIT_LOW || phase == PH_HOLD) |-> pin_clk)
    else $error("shift clock low during bit or hold phase");

  // No request is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst) clearing |-> !q_pop)
    else $error("request taken while frame store clears");

  // A taken request always shows a result next cycle
  assert property (@(posedge clk) disable iff (rst) q_pop |=> out_valid)
    else $error("request taken without a result");

endmodule

// ===== design/led_matrix_scan_driver_core.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver core
// Row-scanning pin sequencer for chained LED matrix panels with a one-bit
// frame store. Request channel: cmd, pixel_row, pixel_col, pixel_value.
// Result channel: the six panel pin levels after each request.
//
// Usage: a request with cmd = 1 writes one pixel bit if in range; cmd = 0
// advances the pin sequence by one tick. Every request returns one result.
// A request is taken on a clock edge with in_valid high and in_stall low;
// a result is taken with out_valid high and out_stall low. Requests pass
// the request queue, then the result register; one request is taken per
// cycle, sustained, while out_stall is low and no clearing pass runs.
// After reset the frame store is cleared one pixel per cycle, NUM_ROWS *
// ROW_BITS pixels (1024 by default), with in_stall high; configuration
// writes are taken throughout. A stalled result holds its pins; the
// two-entry queue keeps taking requests until it fills, then raises
// in_stall. Configuration writes go through cfg_write, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_core
  import lmsd_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [ROW_W-1:0]     pixel_row,
  input  logic [COL_W-1:0]     pixel_col,
  input  logic                 pixel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 addr_a,
  output logic                 addr_b,
  output logic                 latch,
  output logic                 shift_clock,
  output logic                 serial_data,
  output logic                 output_enable
);

  lmsd_cfg_t  cfg;
  logic       q_valid;
  lmsd_item_t q_item;
  logic       q_pop;
  logic       clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.latch_ticks  <= LATCH_TICKS_RST;
      cfg.settle_ticks <= SETTLE_TICKS_RST;
      cfg.hold_ticks   <= HOLD_TICKS_RST;
      cfg.panel_count  <= PANEL_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_LATCH_TICKS:  cfg.latch_ticks  <= TICK_W'(cfg_data);
        CFG_SETTLE_TICKS: cfg.settle_ticks <= TICK_W'(cfg_data);
        CFG_HOLD_TICKS:   cfg.hold_ticks   <= TICK_W'(cfg_data);
        CFG_PANEL_COUNT:  cfg.panel_count  <= cfg_data[PANEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lmsd_front #(
    .NUM_ROWS (NUM_ROWS),
    .ROW_BITS (ROW_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .pixel_value (pixel_value),
    .clearing    (clearing),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lmsd_back #(
    .NUM_ROWS (NUM_ROWS),
    .ROW_BITS (ROW_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .latch         (latch),
    .shift_clock   (shift_clock),
    .serial_data   (serial_data),
    .output_enable (output_enable)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scan driver core testbench
// Sends pixel-write and tick requests through the valid/stall request channel
// and checks every pin-level result against a tick-by-tick scan predictor.
// Register settings change between phases, from all-zero tick counts up to
// full-scale values. Requests come in random bursts and the result side
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import lmsd_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;
  localparam int NUM_PHASES   = 7;
  localparam logic [CFG_W-1:0] TICKS_MAX = 20'hFFFFF;

  typedef struct packed {
    logic addr_a;
    logic addr_b;
    logic latch;
    logic shift_clock;
    logic serial_data;
    logic output_enable;
  } pin_levels_t;

  typedef enum logic [2:0] {
    STEP_ROW_START,
    STEP_LATCH,
    STEP_SETTLE,
    STEP_BIT_HIGH,
    STEP_BIT_LOW,
    STEP_HOLD_START,
    STEP_HOLD
  } scan_step_t;

  typedef struct {
    logic [CFG_W-1:0] latch;
    logic [CFG_W-1:0] settle;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] panels;
    int               items;
  } run_phase_t;

  // Scan predictor and store of expected pin levels
  class scan_scoreboard;
    logic [TICK_W-1:0]  latch_ticks;
    logic [TICK_W-1:0]  settle_ticks;
    logic [TICK_W-1:0]  hold_ticks;
    logic [PANEL_W-1:0] panel_count;
    logic               frame_bits [NUM_ROWS_DEF][ROW_BITS_DEF];
    logic [ROW_W-1:0]   scan_row;
    scan_step_t         step;
    int unsigned        bit_pos;
    int unsigned        wait_left;
    logic               a_toggle;
    logic               b_toggle;
    pin_levels_t        pins;
    pin_levels_t        expected_pins [$];
    int                 mismatches;
    int                 results_checked;
    int                 writes_seen;
    int                 ticks_seen;

    function new();
      latch_ticks  = LATCH_TICKS_RST;
      settle_ticks = SETTLE_TICKS_RST;
      hold_ticks   = HOLD_TICKS_RST;
      panel_count  = PANEL_COUNT_RST;
      foreach (frame_bits[r, c]) frame_bits[r][c] = 1'b0;
      scan_row  = '0;
      step      = STEP_ROW_START;
      bit_pos   = 0;
      wait_left = 0;
      a_toggle  = 1'b1;
      b_toggle  = 1'b1;
      pins      = '0;
      pins.serial_data   = 1'b1;
      pins.output_enable = 1'b1;
      mismatches      = 0;
      results_checked = 0;
      writes_seen     = 0;
      ticks_seen      = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LATCH_TICKS:  latch_ticks  = data[TICK_W-1:0];
        CFG_SETTLE_TICKS: settle_ticks = data[TICK_W-1:0];
        CFG_HOLD_TICKS:   hold_ticks   = data[TICK_W-1:0];
        CFG_PANEL_COUNT:  panel_count  = data[PANEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero tick counts behave as one
    function int unsigned ticks_or_one(logic [TICK_W-1:0] n);
      return (n == 0) ? 1 : int'(n);
    endfunction

    // Clamp the panel count to 1..ROW_BITS/32
    function int unsigned row_length();
      int unsigned panels;
      panels = (panel_count == 0) ? 1 : int'(panel_count);
      if (panels > ROW_BITS_DEF / PANEL_BITS) panels = ROW_BITS_DEF / PANEL_BITS;
      return panels * PANEL_BITS;
    endfunction

    // Toggle the address lines and raise latch
    function void start_row();
      a_toggle = ~a_toggle;
      pins.addr_a = a_toggle;
      pins.latch  = 1'b1;
      if (a_toggle) begin
        b_toggle = ~b_toggle;
        pins.addr_b = b_toggle;
      end
      bit_pos   = 0;
      wait_left = ticks_or_one(latch_ticks) - 1;
      step      = STEP_LATCH;
    endfunction

    // Raise the shift clock with the inverted pixel on data
    function void clock_bit_out();
      pins.shift_clock = 1'b1;
      pins.serial_data = ~frame_bits[scan_row][bit_pos];
      step = STEP_BIT_LOW;
    endfunction

    function void advance_tick();
      case (step)
        STEP_ROW_START: start_row();
        STEP_LATCH: begin
          if (wait_left != 0) begin
            wait_left--;
          end else begin
            pins.latch = 1'b0;
            wait_left  = ticks_or_one(settle_ticks) - 1;
            step       = STEP_SETTLE;
          end
        end
        STEP_SETTLE: begin
          if (wait_left != 0) wait_left--;
          else clock_bit_out();
        end
        STEP_BIT_HIGH: clock_bit_out();
        STEP_BIT_LOW: begin
          pins.shift_clock = 1'b0;
          if (bit_pos + 1 >= row_length()) begin
            bit_pos = 0;
            step    = STEP_HOLD_START;
          end else begin
            bit_pos++;
            step = STEP_BIT_HIGH;
          end
        end
        STEP_HOLD_START: begin
          pins.shift_clock = 1'b1;
          pins.serial_data = 1'b1;
          wait_left = ticks_or_one(hold_ticks) - 1;
          step      = STEP_HOLD;
        end
        default: begin
          if (wait_left != 0) begin
            wait_left--;
          end else begin
            scan_row = scan_row + 1'b1;
            start_row();
          end
        end
      endcase
    endfunction

    // Apply one accepted request and queue the pins it leaves behind
    function void note_request(logic c, logic [ROW_W-1:0] r, logic [COL_W-1:0] col,
                               logic v);
      if (c == CMD_WRITE) begin
        frame_bits[r][col] = v;
        writes_seen++;
      end else begin
        advance_tick();
        ticks_seen++;
      end
      pins.output_enable = 1'b1;
      expected_pins.push_back(pins);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(pin_levels_t got);
      string       names [6];
      string       diff;
      pin_levels_t want;
      logic [5:0]  want_bits;
      logic [5:0]  got_bits;
      names = '{"output_enable", "serial_data", "shift_clock", "latch", "addr_b", "addr_a"};
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with no request waiting: a b lat clk data oe = %b", $time,
                   got);
        return;
      end
      want = expected_pins.pop_front();
      results_checked++;
      want_bits = want;
      got_bits  = got;
      diff = "";
      for (int f = 5; f >= 0; f--) begin
        if (got_bits[f] !== want_bits[f]) diff = {diff, " ", names[f]};
      end
      if (diff != "") begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result %0d differs in%s: a b lat clk data oe expected %b, got %b",
                   $time, results_checked, diff, want_bits, got_bits);
      end
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 cmd         = CMD_TICK;
  logic [ROW_W-1:0]     pixel_row   = '0;
  logic [COL_W-1:0]     pixel_col   = '0;
  logic                 pixel_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic                 addr_a;
  logic                 addr_b;
  logic                 latch;
  logic                 shift_clock;
  logic                 serial_data;
  logic                 output_enable;

  scan_scoreboard sb;
  int             cycle_count      = 0;
  int             settings_applied = 0;
  int             stall_mode       = 0;
  int             stall_left       = 0;

  // Tick counts from zero and small values up to full scale; the stuck-wait
  // settings come last since a full-scale wait never runs out here
  run_phase_t phases [NUM_PHASES] = '{
    '{20'd0,     20'd0,     20'd0,     20'hFFFF0, 260},
    '{20'd3,     20'd2,     20'd5,     20'd1,     220},
    '{20'd1,     20'd1,     20'd2,     20'd15,    150},
    '{20'd2,     20'd1,     20'd3,     20'd8,     200},
    '{20'd2,     20'd1,     20'd2,     20'd1,     370},
    '{20'd1,     20'd1,     TICKS_MAX, 20'd1,     150},
    '{TICKS_MAX, TICKS_MAX, TICKS_MAX, 20'd8,     80}
  };

  led_matrix_scan_driver_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .pixel_row     (pixel_row),
    .pixel_col     (pixel_col),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .latch         (latch),
    .shift_clock   (shift_clock),
    .serial_data   (serial_data),
    .output_enable (output_enable)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(cmd, pixel_row, pixel_col, pixel_value);
      if (out_valid && !out_stall)
        sb.check_result('{addr_a, addr_b, latch, shift_clock, serial_data, output_enable});
    end
  end

  // Stall results in stretches: none, light or heavy
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(4, 48);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("led_matrix_scan_driver_core regression: fail");
      $finish;
    end
  end

  // Hold one request until it is taken
  task automatic send_request(logic c, logic [ROW_W-1:0] r, logic [COL_W-1:0] col, logic v);
    in_valid    <= 1'b1;
    cmd         <= c;
    pixel_row   <= r;
    pixel_col   <= col;
    pixel_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges
  task automatic program_settings(logic [CFG_W-1:0] lat, logic [CFG_W-1:0] settle,
                                  logic [CFG_W-1:0] hold, logic [CFG_W-1:0] panels);
    cfg_index_t       order [4];
    logic [CFG_W-1:0] value [4];
    order = '{CFG_LATCH_TICKS, CFG_SETTLE_TICKS, CFG_HOLD_TICKS, CFG_PANEL_COUNT};
    value = '{lat, settle, hold, panels};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      @(posedge clk);
      sb.write_register(order[i], value[i]);
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random requests, mostly ticks, in bursts with gaps
  task automatic run_random(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_request(($urandom_range(0, 99) < 25) ? CMD_WRITE : CMD_TICK,
                     ROW_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        sent++;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: short waits, column extremes, a column past the row end,
    // and a write to a bit of the current row before it is shifted out
    program_settings(20'd1, 20'd1, 20'd1, 20'd1);
    send_request(CMD_WRITE, 2'd0, 8'd0, 1'b1);
    send_request(CMD_WRITE, 2'd0, 8'd31, 1'b1);
    send_request(CMD_WRITE, 2'd0, 8'd255, 1'b1);
    send_request(CMD_WRITE, 2'd3, 8'd255, 1'b1);
    send_request(CMD_WRITE, 2'd2, 8'd128, 1'b0);
    send_request(CMD_WRITE, 2'd1, 8'd170, 1'b1);
    send_request(CMD_TICK, 2'd3, 8'd255, 1'b1);
    repeat (5) send_request(CMD_TICK, '0, '0, 1'b0);
    send_request(CMD_WRITE, 2'd0, 8'd4, 1'b1);
    send_request(CMD_WRITE, 2'd0, 8'd0, 1'b0);
    repeat (11) send_request(CMD_TICK, '0, '0, 1'b0);
    wait_drained();

    // Random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_settings(phases[p].latch, phases[p].settle, phases[p].hold, phases[p].panels);
      run_random(phases[p].items);
      wait_drained();
    end

    $display("covered %0d requests (%0d pixel writes, %0d ticks) over %0d register settings",
             sb.writes_seen + sb.ticks_seen, sb.writes_seen, sb.ticks_seen, settings_applied);
    $display("checked %0d pin results, %0d mismatches", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("led_matrix_scan_driver_core regression: pass");
    end else begin
      $display("led_matrix_scan_driver_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lmsd_pkg.sv
design/lmsd_front.sv
design/lmsd_back.sv
design/led_matrix_scan_driver_core.sv
verif/tb_top.sv
